FILE: rtl/current_sample_monitor_unit_defines.svh
// Assertion macros for the current sample monitor.
// Included by the top level; no other dependencies.
`ifndef CURRENT_SAMPLE_MONITOR_UNIT_DEFINES_SVH
`define CURRENT_SAMPLE_MONITOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CSM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("csm check failed");
`define CSM_ASSERT_NORST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("csm check failed");
`else
`define CSM_ASSERT(lbl, clk, rst_n, prop)
`define CSM_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

FILE: rtl/csm_pkg.sv
// Package for the current sample monitor: sizes, register indexes, status codes, sequencer states.
// No dependencies.
`default_nettype none
package csm_pkg;
	localparam int GroupSamples = 10;
	localparam int AvgWindow = 8;
	localparam int StatWindow = 50;
	localparam int AvgLog = 3;

	localparam logic [2:0] RegDeadband = 3'd0;
	localparam logic [2:0] RegSupply   = 3'd1;
	localparam logic [2:0] RegDetect   = 3'd2;
	localparam logic [2:0] RegStartup  = 3'd3;
	localparam logic [2:0] RegRunning  = 3'd4;
	localparam logic [2:0] RegNoise    = 3'd5;

	localparam logic [2:0] StStopped  = 3'd0;
	localparam logic [2:0] StRunning  = 3'd1;
	localparam logic [2:0] StStarting = 3'd2;
	localparam logic [2:0] StDetected = 3'd3;
	localparam logic [2:0] StNoise    = 3'd4;
	localparam logic [2:0] StWeak     = 3'd5;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DIV   = 7'b0000010,
		S_RING  = 7'b0000100,
		S_SQ    = 7'b0001000,
		S_MS    = 7'b0010000,
		S_SQRT  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;
endpackage
`default_nettype wire

FILE: rtl/current_sample_monitor_unit.sv
// Current sample monitor: deadband, group and moving average, window stats, rms, power, load status.
// Depends on csm_pkg and current_sample_monitor_unit_defines.svh.
//
// A sample that does not complete a group of ten is added to the group sum. A
// completing sample runs a sequencer: a bit-serial divide by ten, a ring step,
// a shift-add square, a restoring divide of the square sum by the window count,
// a load step, a 16-step digit-by-digit square root with the power product
// formed by shift-add alongside it, a divide of the power product by 1000 and an
// output step. The serial dividers take up most of the sequence.
// No input is taken until the result word has been taken by the receiver.
// Configuration writes are taken at any time.
`default_nettype none
`include "current_sample_monitor_unit_defines.svh"
module current_sample_monitor_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] sample_ma,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      present_ma,
	output logic signed [15:0]      smoothed_ma,
	output logic signed [15:0]      peak_high_ma,
	output logic signed [15:0]      peak_low_ma,
	output logic [15:0]             rms_ma,
	output logic [21:0]             power_mw,
	output logic [5:0]              window_count,
	output logic [2:0]              load_status
);
	// config registers
	logic [14:0] deadband_q, detect_q, startup_q, running_q, noise_q;
	logic [15:0] supply_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= 15'd50;
			supply_q   <= 16'd5000;
			detect_q   <= 15'd100;
			startup_q  <= 15'd200;
			running_q  <= 15'd300;
			noise_q    <= 15'd50;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				csm_pkg::RegDeadband: deadband_q <= cfg_data[14:0];
				csm_pkg::RegSupply:   supply_q   <= cfg_data;
				csm_pkg::RegDetect:   detect_q   <= cfg_data[14:0];
				csm_pkg::RegStartup:  startup_q  <= cfg_data[14:0];
				csm_pkg::RegRunning:  running_q  <= cfg_data[14:0];
				csm_pkg::RegNoise:    noise_q    <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	csm_pkg::state_t state_q;
	logic accept_in, accept_out;
	assign in_stall   = (state_q != csm_pkg::S_IDLE) || out_valid;
	assign accept_in  = in_valid && !in_stall;
	assign accept_out = out_valid && !out_stall;

	// deadband on the incoming sample
	logic [16:0] in_mag;
	logic signed [15:0] in_db;
	assign in_mag = sample_ma[15] ? (17'd0 - {sample_ma[15], sample_ma}) : {1'b0, sample_ma};
	assign in_db  = (in_mag < {2'b00, deadband_q}) ? 16'sd0 : sample_ma;

	logic signed [19:0] gsum_q;
	logic [3:0] gfill_q;
	logic signed [15:0] ring_q [csm_pkg::AvgWindow];
	logic [2:0] rptr_q;
	logic signed [18:0] rsum_q;
	logic [5:0] scount_q;
	logic signed [15:0] shigh_q, slow_q;
	logic [36:0] sqsum_q;

	// shared serial divider: quotient/remainder shifting
	logic [36:0] dnum_q;     // numerator shifting out, quotient shifting in
	logic [20:0] drem_q;     // partial remainder
	logic [5:0] dcnt_q;
	logic signed [15:0] present_q;
	logic [15:0] pmag_q;
	logic [31:0] prod_q;     // square/power product
	logic [15:0] mcand_q;
	logic [33:0] root_rem_q;
	logic [15:0] root_q;
	logic [36:0] ms_q;
	logic dneg_q;
	logic [1:0] phase_q;     // 0 group, 1 mean square, 2 power

	logic [20:0] trial;
	logic [20:0] dsor;
	always_comb begin
		case (phase_q)
			2'd0: dsor = 21'd10;
			2'd1: dsor = {15'd0, scount_q};
			default: dsor = 21'd1000;
		endcase
		trial = {drem_q[19:0], dnum_q[36]};
	end

	// ring add and averaged value
	logic signed [18:0] rsum_next;
	logic [18:0] rabs;
	logic signed [15:0] smooth;
	assign rsum_next = rsum_q + 19'(present_q) - 19'(ring_q[rptr_q]);
	assign rabs = rsum_q[18] ? (19'd0 - rsum_q) : rsum_q;
	assign smooth = rsum_q[18] ? 16'(0 - (rabs >> csm_pkg::AvgLog))
	                           : 16'(rabs >> csm_pkg::AvgLog);

	// square root step
	logic [33:0] rtrial;
	assign rtrial = {root_rem_q[31:0], ms_q[31:30]} - {16'd0, root_q, 2'b01};

	logic [16:0] pres_mag_w;
	assign pres_mag_w = {1'b0, pmag_q};

	logic [2:0] status;
	always_comb begin
		if (pmag_q == 16'd0 && root_q < {1'b0, noise_q}) status = csm_pkg::StStopped;
		else if (root_q >= {1'b0, running_q}) status = csm_pkg::StRunning;
		else if (root_q >= {1'b0, startup_q}) status = csm_pkg::StStarting;
		else if (pres_mag_w >= {2'b00, detect_q}) status = csm_pkg::StDetected;
		else if (pmag_q == 16'd0) status = csm_pkg::StNoise;
		else status = csm_pkg::StWeak;
	end

	logic [19:0] qmag;
	logic signed [19:0] qsig;
	logic [16:0] qabs;
	assign qmag = dnum_q[19:0];
	assign qsig = dneg_q ? (20'd0 - qmag) : qmag;
	assign qabs = qmag[16:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csm_pkg::S_IDLE;
			out_valid <= 1'b0;
			gsum_q <= '0; gfill_q <= '0; rptr_q <= '0; rsum_q <= '0;
			scount_q <= '0; shigh_q <= '0; slow_q <= '0; sqsum_q <= '0;
			for (int i = 0; i < csm_pkg::AvgWindow; i++) ring_q[i] <= '0;
			phase_q <= 2'd0; dcnt_q <= '0;
			dnum_q <= '0; drem_q <= '0; dneg_q <= 1'b0;
			present_q <= '0; pmag_q <= '0; prod_q <= '0; mcand_q <= '0;
			root_rem_q <= '0; root_q <= '0; ms_q <= '0;
			present_ma <= '0; smoothed_ma <= '0; peak_high_ma <= '0; peak_low_ma <= '0;
			rms_ma <= '0; power_mw <= '0; window_count <= '0; load_status <= '0;
		end else begin
			if (accept_out) out_valid <= 1'b0;
			unique case (state_q)
				csm_pkg::S_IDLE: if (accept_in) begin
					if (gfill_q == 4'(csm_pkg::GroupSamples - 1)) begin
						logic signed [19:0] tot;
						tot = gsum_q + 20'(in_db);
						dneg_q <= tot[19];
						// magnitude at the top so it shifts out MSB first
						dnum_q <= {tot[19] ? (20'd0 - tot) : tot, 17'd0};
						drem_q <= '0;
						dcnt_q <= 6'd20;
						phase_q <= 2'd0;
						gsum_q <= '0; gfill_q <= '0;
						state_q <= csm_pkg::S_DIV;
					end else begin
						gsum_q <= gsum_q + 20'(in_db);
						gfill_q <= gfill_q + 4'd1;
					end
				end
				csm_pkg::S_DIV: begin
					// one restoring quotient bit per cycle
					if (trial >= dsor) begin
						drem_q <= trial - dsor;
						dnum_q <= {dnum_q[35:0], 1'b1};
					end else begin
						drem_q <= trial;
						dnum_q <= {dnum_q[35:0], 1'b0};
					end
					dcnt_q <= dcnt_q - 6'd1;
					if (dcnt_q == 6'd1) begin
						unique case (phase_q)
							2'd0: state_q <= csm_pkg::S_RING;
							2'd1: state_q <= csm_pkg::S_MS;
							default: state_q <= csm_pkg::S_OUT;
						endcase
					end
				end
				csm_pkg::S_RING: begin
					// deadband on the group average
					logic signed [15:0] p;
					p = (qabs < {2'b00, deadband_q}) ? 16'sd0 : qsig[15:0];
					present_q <= p;
					pmag_q <= (qabs < {2'b00, deadband_q}) ? 16'd0 : qabs[15:0];
					mcand_q <= (qabs < {2'b00, deadband_q}) ? 16'd0 : qabs[15:0];
					prod_q <= '0;
					dcnt_q <= 6'd16;
					state_q <= csm_pkg::S_SQ;
				end
				csm_pkg::S_SQ: begin
					// shift-add square, multiplier bits MSB first
					logic [31:0] acc;
					if (dcnt_q == 6'd16) begin
						// first cycle also folds in ring and window updates
						rsum_q <= rsum_next;
						ring_q[rptr_q] <= present_q;
						rptr_q <= rptr_q + 3'd1;
						if (scount_q >= 6'(csm_pkg::StatWindow) || scount_q == 6'd0) begin
							scount_q <= 6'd1;
							shigh_q <= present_q; slow_q <= present_q;
						end else begin
							scount_q <= scount_q + 6'd1;
							if (present_q > shigh_q) shigh_q <= present_q;
							if (present_q < slow_q) slow_q <= present_q;
						end
					end
					acc = {prod_q[30:0], 1'b0} + (mcand_q[15] ? {16'd0, pmag_q} : 32'd0);
					prod_q <= acc;
					mcand_q <= {mcand_q[14:0], 1'b0};
					dcnt_q <= dcnt_q - 6'd1;
					if (dcnt_q == 6'd1) begin
						logic [36:0] ns;
						ns = (scount_q == 6'd1) ? {5'd0, acc} : sqsum_q + {5'd0, acc};
						sqsum_q <= ns;
						dnum_q <= ns;
						drem_q <= '0;
						dneg_q <= 1'b0;
						phase_q <= 2'd1;
						dcnt_q <= 6'd37;
						state_q <= csm_pkg::S_DIV;
					end
				end
				csm_pkg::S_MS: begin
					ms_q <= dnum_q;
					root_rem_q <= '0;
					root_q <= '0;
					// supply bits drive the power shift-add, MSB first
					mcand_q <= supply_q;
					prod_q <= '0;
					dcnt_q <= 6'd16;
					state_q <= csm_pkg::S_SQRT;
				end
				csm_pkg::S_SQRT: begin
					logic [31:0] pacc;
					// two radicand bits per step, one root bit out
					if (!rtrial[33]) begin
						root_rem_q <= rtrial;
						root_q <= {root_q[14:0], 1'b1};
					end else begin
						root_rem_q <= {root_rem_q[31:0], ms_q[31:30]};
						root_q <= {root_q[14:0], 1'b0};
					end
					ms_q <= {ms_q[34:0], 2'b00};
					// power product: |smoothed| times supply
					pacc = {prod_q[30:0], 1'b0} + (mcand_q[15] ? {16'd0, rabs[18:3]} : 32'd0);
					prod_q <= pacc;
					mcand_q <= {mcand_q[14:0], 1'b0};
					dcnt_q <= dcnt_q - 6'd1;
					if (dcnt_q == 6'd1) begin
						dnum_q <= {5'd0, pacc};
						drem_q <= '0;
						phase_q <= 2'd2;
						dcnt_q <= 6'd37;
						state_q <= csm_pkg::S_DIV;
					end
				end
				csm_pkg::S_OUT: begin
					present_ma <= present_q;
					smoothed_ma <= smooth;
					peak_high_ma <= shigh_q;
					peak_low_ma <= slow_q;
					rms_ma <= root_q;
					power_mw <= dnum_q[21:0];
					window_count <= scount_q;
					load_status <= status;
					out_valid <= 1'b1;
					state_q <= csm_pkg::S_IDLE;
				end
				default: state_q <= csm_pkg::S_IDLE;
			endcase
		end
	end

	// checks
	`CSM_ASSERT(a_onehot, clk, arst_n, $onehot(state_q))
	`CSM_ASSERT(a_no_in_busy, clk, arst_n, (state_q != csm_pkg::S_IDLE) |-> in_stall)
	`CSM_ASSERT(a_out_from_seq, clk, arst_n, $rose(out_valid) |-> $past(state_q == csm_pkg::S_OUT))
	`CSM_ASSERT(a_count_range, clk, arst_n, out_valid |-> (window_count != 6'd0 && window_count <= 6'(csm_pkg::StatWindow)))
endmodule
`default_nettype wire
